FILE: rtl/spaf_pkg.sv
// ----------------------------------------------------------------------------
// spaf_pkg
// Shared types and constants of the sparse accumulator: field widths, request
// kinds, decoded operations, queue entry and back-end state codes.
// ----------------------------------------------------------------------------
package spaf_pkg;

  localparam int KIND_W       = 2;
  localparam int COORD_W      = 20;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 11;
  localparam int DEF_CAPACITY = 1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REWIND = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DROP,
    OP_REWIND,
    OP_NEXT,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] coord;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_INS,
    ST_SCAN,
    ST_CLR
  } state_e;

endpackage

FILE: rtl/spaf_ram.sv
// ----------------------------------------------------------------------------
// spaf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/spaf_front.sv
// ----------------------------------------------------------------------------
// spaf_front
// Input side: takes request beats, classifies them (out-of-range inserts
// become drops) and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module spaf_front import spaf_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [COORD_W-1:0] coord_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               q_valid_o,
  output item_t              q_item_o,
  input  logic               q_pop_i
);

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.coord = coord_i;
    cls.value = value_i;
    case (kind_e'(kind_i))
      KIND_INSERT: begin
        cls.op = (32'(coord_i) >= 32'(CAPACITY)) ? OP_DROP : OP_INSERT;
      end
      KIND_REWIND: cls.op = OP_REWIND;
      KIND_NEXT:   cls.op = OP_NEXT;
      default:     cls.op = OP_CLEAR;
    endcase
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

FILE: rtl/spaf_back.sv
// ----------------------------------------------------------------------------
// spaf_back
// Execution side: slot memory ({occupied, sum}) and coordinate list, insert
// read-modify-write, ordered scan for next, list walk for clear, result
// register.
// ----------------------------------------------------------------------------
module spaf_back import spaf_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  item_t              q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] entry_coord_o,
  output logic [VALUE_W-1:0] entry_value_o,
  output logic               found_o,
  output logic               is_last_o,
  output logic [COUNT_W-1:0] entry_count_o,
  output logic               dropped_o
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SLOT_W = VALUE_W + 1;

  state_e state_q, state_d;

  logic [IDX_W-1:0]   init_idx_q;
  logic [IDX_W-1:0]   ins_idx_q;
  logic [VALUE_W-1:0] ins_val_q;
  logic [CNT_W-1:0]   count_q, cursor_q, rank_q, clr_idx_q;
  logic               overflow_q;
  logic [IDX_W:0]     scan_addr_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               rd_vld_q, lst_vld_q;

  logic               out_valid_q, found_q, last_q;
  logic [COORD_W-1:0] coord_q;
  logic [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]   ocount_q;
  logic               dropped_q;

  logic              slot_we, slot_re, list_we, list_re;
  logic [IDX_W-1:0]  slot_waddr, slot_raddr, list_waddr, list_raddr;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;
  logic [IDX_W-1:0]  list_rdata;

  logic out_free, take, scan_issue, scan_hit, scan_end, clr_issue, clr_done;
  logic slot_used, ins_new, init_last, load_miss, zero_regs;
  logic [31:0] ocount32;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign take       = (state_q == ST_IDLE) && q_valid_i &&
                      (q_item_i.op != OP_NEXT || out_free);
  assign slot_used  = slot_rdata[SLOT_W-1];
  assign ins_new    = !slot_used && (count_q < CNT_W'(CAPACITY));
  assign init_last  = (init_idx_q == IDX_W'(CAPACITY - 1));
  assign scan_issue = (state_q == ST_SCAN) && (32'(scan_addr_q) < 32'(CAPACITY));
  assign scan_hit   = (state_q == ST_SCAN) && rd_vld_q && slot_used &&
                      (rank_q == cursor_q);
  assign scan_end   = !scan_issue && !rd_vld_q;
  assign clr_issue  = (state_q == ST_CLR) && (clr_idx_q < count_q);
  assign clr_done   = (clr_idx_q == count_q) && !lst_vld_q;
  assign load_miss  = take && (q_item_i.op == OP_NEXT) && (cursor_q >= count_q);
  assign zero_regs  = (take && q_item_i.op == OP_CLEAR && count_q == '0) ||
                      (state_q == ST_CLR && clr_done);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: if (init_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          case (q_item_i.op)
            OP_INSERT: state_d = ST_INS;
            OP_NEXT:   if (cursor_q < count_q) state_d = ST_SCAN;
            OP_CLEAR:  if (count_q != '0) state_d = ST_CLR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS:  state_d = ST_IDLE;
      ST_SCAN: if (scan_hit || scan_end) state_d = ST_IDLE;
      ST_CLR:  if (clr_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    q_pop_o    = take;
    slot_we    = 1'b0;
    slot_waddr = ins_idx_q;
    slot_wdata = {1'b1, ins_val_q};
    slot_re    = 1'b0;
    slot_raddr = q_item_i.coord[IDX_W-1:0];
    list_we    = 1'b0;
    list_waddr = count_q[IDX_W-1:0];
    list_re    = clr_issue;
    list_raddr = clr_idx_q[IDX_W-1:0];
    case (state_q)
      ST_INIT: begin
        slot_we    = 1'b1;
        slot_waddr = init_idx_q;
        slot_wdata = '0;
      end
      ST_IDLE: slot_re = take && (q_item_i.op == OP_INSERT);
      ST_INS: begin
        slot_we = 1'b1;
        if (slot_used) begin
          slot_wdata = {1'b1, slot_rdata[VALUE_W-1:0] + ins_val_q};
        end
        list_we = ins_new;
      end
      ST_SCAN: begin
        slot_re    = scan_issue;
        slot_raddr = scan_addr_q[IDX_W-1:0];
      end
      ST_CLR: begin
        // clear the flag and the sum of each listed coordinate
        slot_we    = lst_vld_q;
        slot_waddr = list_rdata;
        slot_wdata = '0;
      end
      default: slot_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ins_idx_q <= q_item_i.coord[IDX_W-1:0];
      ins_val_q <= q_item_i.value;
    end
    if (load_miss) begin
      coord_q <= '0;
      value_q <= '0;
      last_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (scan_hit) begin
      coord_q <= COORD_W'(rd_idx_q);
      value_q <= slot_rdata[VALUE_W-1:0];
      last_q  <= (cursor_q + CNT_W'(1) == count_q);
      found_q <= 1'b1;
    end
    if (load_miss || scan_hit) begin
      ocount_q  <= count_q;
      dropped_q <= overflow_q;
    end
    rd_idx_q <= scan_addr_q[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_idx_q  <= '0;
      count_q     <= '0;
      cursor_q    <= '0;
      overflow_q  <= 1'b0;
      rank_q      <= '0;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      clr_idx_q   <= '0;
      lst_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT) begin
        init_idx_q <= init_idx_q + IDX_W'(1);
      end
      if (take && q_item_i.op == OP_DROP) begin
        overflow_q <= 1'b1;
      end
      if (take && q_item_i.op == OP_REWIND) begin
        cursor_q <= '0;
      end
      if (state_q == ST_INS && ins_new) begin
        count_q <= count_q + CNT_W'(1);
      end
      // scan and clear bookkeeping
      if (take) begin
        scan_addr_q <= '0;
        rank_q      <= '0;
        rd_vld_q    <= 1'b0;
        clr_idx_q   <= '0;
        lst_vld_q   <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (scan_hit) begin
          rd_vld_q <= 1'b0;
          cursor_q <= cursor_q + CNT_W'(1);
        end else begin
          rd_vld_q <= scan_issue;
          if (scan_issue) begin
            scan_addr_q <= scan_addr_q + (IDX_W+1)'(1);
          end
          if (rd_vld_q && slot_used) begin
            rank_q <= rank_q + CNT_W'(1);
          end
        end
      end else if (state_q == ST_CLR) begin
        lst_vld_q <= clr_issue;
        if (clr_issue) begin
          clr_idx_q <= clr_idx_q + CNT_W'(1);
        end
      end
      if (zero_regs) begin
        count_q    <= '0;
        cursor_q   <= '0;
        overflow_q <= 1'b0;
      end
      if (load_miss || scan_hit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  spaf_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  spaf_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (ins_idx_q),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  assign ocount32      = 32'(ocount_q);
  assign out_valid_o   = out_valid_q;
  assign entry_coord_o = coord_q;
  assign entry_value_o = value_q;
  assign found_o       = found_q;
  assign is_last_o     = last_q;
  assign entry_count_o = ocount32[COUNT_W-1:0];
  assign dropped_o     = dropped_q;

endmodule

FILE: rtl/sparse_accumulator_flagged_top.sv
// ----------------------------------------------------------------------------
// sparse_accumulator_flagged_top
// Sparse accumulator for one output row with occupied flags and a
// coordinate list.
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot memory, one slot per cycle, and
// executes no request until that pass is done. Requests then enter a
// two-entry queue and run one at a time. An insert reads the slot memory,
// then adds and writes back the slot; a rewind or an out-of-range insert
// completes without leaving the idle state; a next walks the slot flags one
// coordinate per cycle from zero, or returns a not-found result without a
// walk once the read-out is exhausted; a clear walks the coordinate list, or
// completes without a walk when the list is empty. The result register lets
// requests other than next proceed while a next result waits to be taken.
module sparse_accumulator_flagged_top import spaf_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [COORD_W-1:0] coord_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] entry_coord_o,
  output logic [VALUE_W-1:0] entry_value_o,
  output logic               found_o,
  output logic               is_last_o,
  output logic [COUNT_W-1:0] entry_count_o,
  output logic               dropped_o
);

  logic  q_valid, q_pop;
  item_t q_item;

  spaf_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .coord_i    (coord_i),
    .value_i    (value_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  spaf_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_coord_o (entry_coord_o),
    .entry_value_o (entry_value_o),
    .found_o       (found_o),
    .is_last_o     (is_last_o),
    .entry_count_o (entry_count_o),
    .dropped_o     (dropped_o)
  );

endmodule

FILE: rtl/spaf_checker.sv
// ----------------------------------------------------------------------------
// spaf_checker
// Port-level checks of the sparse accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module spaf_checker import spaf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [COORD_W-1:0] entry_coord_o,
  input logic [VALUE_W-1:0] entry_value_o,
  input logic               found_o,
  input logic               is_last_o,
  input logic [COUNT_W-1:0] entry_count_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> !is_last_o && entry_coord_o == '0 &&
      entry_value_o == '0)
    else $error("exhausted result carries data");

  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> entry_count_o != '0)
    else $error("entry returned with zero count");

endmodule

bind sparse_accumulator_flagged_top spaf_checker u_spaf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .entry_coord_o (entry_coord_o),
  .entry_value_o (entry_value_o),
  .found_o       (found_o),
  .is_last_o     (is_last_o),
  .entry_count_o (entry_count_o)
);

FILE: bench/spaf_checker.sv
// ----------------------------------------------------------------------------
// spaf_tb_checker
// Watches the request and result channels of the sparse accumulator, keeps
// its own copy of slot sums, occupied flags and entry list, predicts each
// next result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module spaf_tb_checker import spaf_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [COORD_W-1:0] coord_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [COORD_W-1:0] entry_coord_i,
  input  logic [VALUE_W-1:0] entry_value_i,
  input  logic               found_i,
  input  logic               is_last_i,
  input  logic [COUNT_W-1:0] entry_count_i,
  input  logic               dropped_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o
);

  typedef struct packed {
    logic [COORD_W-1:0] ecoord;
    logic [VALUE_W-1:0] evalue;
    logic               found;
    logic               last;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } entry_res_t;

  logic [VALUE_W-1:0] sums [CAPACITY];
  logic               used [CAPACITY];
  int unsigned        order_list [CAPACITY];
  int unsigned        n_used;
  int unsigned        cursor;
  logic               ovf;
  entry_res_t         expected_q [$];

  function automatic entry_res_t fetch_next();
    entry_res_t r;
    int unsigned rank;
    r = '0;
    rank = 0;
    if (cursor < n_used) begin
      for (int c = 0; c < CAPACITY; c++) begin
        if (used[c]) begin
          if (rank == cursor) begin
            r.ecoord = COORD_W'(c);
            r.evalue = sums[c];
            r.found  = 1'b1;
            r.last   = (cursor + 1 == n_used);
            break;
          end
          rank++;
        end
      end
      if (r.found) cursor++;
    end
    r.count   = COUNT_W'(n_used);
    r.dropped = ovf;
    return r;
  endfunction

  task automatic apply_request(kind_e k, logic [COORD_W-1:0] c, logic [VALUE_W-1:0] v);
    entry_res_t nxt;
    case (k)
      KIND_INSERT: begin
        if (c >= CAPACITY) begin
          ovf = 1'b1;
        end else if (!used[c]) begin
          used[c] = 1'b1;
          sums[c] = v;
          if (n_used < CAPACITY) begin
            order_list[n_used] = 32'(c);
            n_used++;
          end
        end else begin
          sums[c] = sums[c] + v;
        end
      end
      KIND_REWIND: cursor = 0;
      KIND_NEXT: begin
        nxt = fetch_next();
        expected_q = {expected_q, nxt};
      end
      default: begin
        for (int i = 0; i < n_used; i++) used[order_list[i]] = 1'b0;
        n_used = 0;
        cursor = 0;
        ovf    = 1'b0;
      end
    endcase
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      used[i] = 1'b0;
      sums[i] = '0;
    end
    n_used = 0;
    cursor = 0;
    ovf = 1'b0;
    fail_count_o = 0;
    results_seen_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    entry_res_t got, want;
    if (rst_ni && in_valid_i && !in_stall_i)
      apply_request(kind_e'(kind_i), coord_i, value_i);
    if (rst_ni && out_valid_i && !out_stall_i) begin
      got = '{entry_coord_i, entry_value_i, found_i, is_last_i, entry_count_i, dropped_i};
      results_seen_o <= results_seen_o + 1;
      if (expected_q.size() == 0) begin
        fail_count_o <= fail_count_o + 1;
        if (fail_count_o < 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    pending_o <= expected_q.size();
  end

endmodule

FILE: bench/sparse_accumulator_flagged_top_tb.sv
// ----------------------------------------------------------------------------
// sparse_accumulator_flagged_top_tb
// Drives directed and random insert, rewind, next and clear requests with
// random gaps and result-side stalls, one long hold-off that backs up the
// block, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module sparse_accumulator_flagged_top_tb;
  import spaf_pkg::*;

  localparam int CAP = DEF_CAPACITY;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [KIND_W-1:0]  kind_i = KIND_REWIND;
  logic [COORD_W-1:0] coord_i = '0;
  logic [VALUE_W-1:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic [COORD_W-1:0] entry_coord_o;
  logic [VALUE_W-1:0] entry_value_o;
  logic               found_o, is_last_o, dropped_o;
  logic [COUNT_W-1:0] entry_count_o;
  int                 fail_count, pending, results_seen;
  int                 n_items;
  bit                 hold_off;

  always #5 clk_i = ~clk_i;

  sparse_accumulator_flagged_top #(.CAPACITY(CAP)) i_dut (.*);

  spaf_tb_checker #(.CAPACITY(CAP)) i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .coord_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .entry_coord_i(entry_coord_o),
    .entry_value_i(entry_value_o), .found_i(found_o), .is_last_i(is_last_o),
    .entry_count_i(entry_count_o), .dropped_i(dropped_o), .fail_count_o(fail_count),
    .pending_o(pending), .results_seen_o(results_seen)
  );

  // send one beat after a gap, hold it until accepted; drop valid only in a gap
  task automatic send(kind_e k, logic [COORD_W-1:0] c, logic [VALUE_W-1:0] v, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    coord_i <= c;
    value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    n_items++;
  endtask

  task automatic send_rand_gap(kind_e k, logic [COORD_W-1:0] c, logic [VALUE_W-1:0] v);
    send(k, c, v, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11));
  endtask

  // mostly small in-range coordinates, sometimes near the top edge, just past it or anywhere in the field
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_W'($urandom);
      1:       return COORD_W'(CAP - 1 - $urandom_range(0, 3));
      2:       return COORD_W'(CAP + $urandom_range(0, 3));
      default: return COORD_W'($urandom_range(0, 63));
    endcase
  endfunction

  // result side: random stall per beat, long hold-off on request
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_n == 0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        repeat (wait_n - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int guard;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every kind, overflow, first insert and exhausted read-out
    send(KIND_NEXT, 0, 0, 0);
    send(KIND_INSERT, 0, 32'h7FFF_FFFF, 0);
    send(KIND_INSERT, 0, 32'h0000_0001, 0);
    send(KIND_INSERT, COORD_W'(CAP - 1), 32'h8000_0000, 0);
    send(KIND_INSERT, COORD_W'(CAP - 1), 32'hFFFF_FFFF, 1);
    send(KIND_INSERT, 20'hFFFFF, 32'h1234_5678, 0);
    send(KIND_INSERT, COORD_W'(CAP), 32'h1, 0);
    send(KIND_INSERT, 5, 32'hAAAA_AAAA, 0);
    send(KIND_INSERT, 10, 32'h5555_5555, 0);
    send(KIND_NEXT, 0, 0, 0);
    send(KIND_INSERT, 3, 32'h0000_0007, 0);
    for (int i = 0; i < 5; i++) send(KIND_NEXT, 0, 0, 0);
    send(KIND_REWIND, 20'hFFFFF, 32'hFFFF_FFFF, 0);
    send(KIND_NEXT, 0, 0, 2);
    send(KIND_CLEAR, 0, 0, 0);
    send(KIND_NEXT, 0, 0, 0);
    send(KIND_INSERT, 7, 32'h0, 0);
    send(KIND_NEXT, 0, 0, 0);
    send(KIND_CLEAR, 0, 0, 0);
    // fill the block while the result side holds off
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send(KIND_NEXT, 0, 0, 0);
    // random: bursts of inserts then a read-out, with noise in between
    while (n_items < 480) begin
      repeat ($urandom_range(2, 14)) begin
        if ($urandom_range(0, 9) == 0)
          send_rand_gap(kind_e'(KIND_W'($urandom_range(0, 3))), COORD_W'($urandom),
                        $urandom);
        else
          send_rand_gap(KIND_INSERT, pick_coord(), $urandom);
      end
      send_rand_gap(KIND_REWIND, COORD_W'($urandom), $urandom);
      repeat ($urandom_range(1, 12)) send_rand_gap(KIND_NEXT, COORD_W'($urandom), $urandom);
      if ($urandom_range(0, 3) == 0) send_rand_gap(KIND_CLEAR, COORD_W'($urandom), $urandom);
    end
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * CAP + 20) @(posedge clk_i);
    $display("covered %0d request beats and %0d next results", n_items, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
